### hw/rtl/epsm_pkg.sv
// Shared types and constants for the exact pattern stream matcher.
// Holds the beat function codes, controller states and the command/status structs.
// Depends on nothing.
`timescale 1ns / 1ps

package epsm_pkg;

	localparam int MAX_PAT = 64;
	localparam int PAT_AW  = $clog2(MAX_PAT);
	localparam int LEN_W   = PAT_AW + 1;
	localparam int IDX_W   = 32;
	localparam int SYM_W   = 8;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAT);

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_TEXT   = 2'd2,
		FUNC_NONE   = 2'd3
	} epsm_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHECK,
		ST_EMIT
	} epsm_state_t;

	typedef struct packed {
		logic accept;
		logic fetch;
		logic advance;
		logic load_out;
	} epsm_cmd_t;

	typedef struct packed {
		logic scan_req;
		logic equal;
		logic last;
		logic out_free;
	} epsm_status_t;

endpackage

### hw/rtl/epsm_ctrl.sv
// Controller state machine of the exact pattern stream matcher.
// Sequences beat acceptance, the byte-by-byte compare loop and result loading.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

module epsm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  epsm_pkg::epsm_status_t status,
	output epsm_pkg::epsm_cmd_t    cmd
);
	import epsm_pkg::*;

	epsm_state_t state_q;
	epsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.scan_req) begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (!status.equal) begin
					state_d = ST_IDLE;
				end else if (status.last) begin
					state_d = ST_EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_FETCH;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/epsm_datapath.sv
// Datapath of the exact pattern stream matcher: pattern and text memories,
// counters, the byte comparator and the output register.
// Depends on epsm_pkg.
`timescale 1ns / 1ps

module epsm_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   func,
	input  logic [epsm_pkg::SYM_W-1:0]   symbol,
	input  epsm_pkg::epsm_cmd_t          cmd,
	output epsm_pkg::epsm_status_t       status,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [epsm_pkg::IDX_W-1:0]   match_start,
	output logic                         pattern_overflow
);
	import epsm_pkg::*;

	logic [SYM_W-1:0]  pat_mem [MAX_PAT];
	logic [SYM_W-1:0]  win_mem [MAX_PAT];

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [LEN_W-1:0]  fill_plus;
	logic [PAT_AW-1:0] wptr_q;
	logic [PAT_AW-1:0] base_q;
	logic [PAT_AW-1:0] k_q;
	logic [PAT_AW-1:0] win_ra;
	logic [IDX_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  match_q;
	logic              ovf_q;
	logic              ovf_out_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  pat_rd_q;
	logic [SYM_W-1:0]  win_rd_q;
	logic              pat_we;
	logic [PAT_AW-1:0] pat_wa;
	logic              win_we;

	assign fill_plus = (fill_q == LEN_MAX) ? fill_q : fill_q + LEN_W'(1);
	assign win_ra    = base_q + k_q;

	assign pat_we = cmd.accept && ((func == FUNC_START) ||
		((func == FUNC_APPEND) && (len_q < LEN_MAX)));
	assign pat_wa = (func == FUNC_START) ? '0 : len_q[PAT_AW-1:0];
	assign win_we = cmd.accept && (func == FUNC_TEXT);

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[pat_wa] <= symbol;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[wptr_q] <= symbol;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			pat_rd_q <= pat_mem[k_q];
			win_rd_q <= win_mem[win_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			fill_q  <= '0;
			wptr_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			if (cmd.accept) begin
				k_q <= '0;
				case (func)
					FUNC_START: begin
						len_q   <= LEN_W'(1);
						ovf_q   <= 1'b0;
						count_q <= '0;
						fill_q  <= '0;
					end
					FUNC_APPEND: begin
						if (len_q < LEN_MAX) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					FUNC_TEXT: begin
						wptr_q  <= wptr_q + PAT_AW'(1);
						fill_q  <= fill_plus;
						count_q <= count_q + IDX_W'(1);
					end
					default: begin
					end
				endcase
			end else if (cmd.advance) begin
				k_q <= k_q + PAT_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			base_q <= wptr_q + PAT_AW'(1) - len_q[PAT_AW-1:0];
			idx_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			match_q   <= idx_q - IDX_W'(len_q) + IDX_W'(1);
			ovf_out_q <= ovf_q;
		end
	end

	assign status.scan_req = (func == FUNC_TEXT) && (len_q != '0) && (fill_plus >= len_q);
	assign status.equal    = (pat_rd_q == win_rd_q);
	assign status.last     = ({1'b0, k_q} == (len_q - LEN_W'(1)));
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign match_start      = match_q;
	assign pattern_overflow = ovf_out_q;

`ifndef ASSERT_OFF
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("Pattern length exceeds capacity.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_MAX)
		else $error("Window fill count exceeds capacity.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("Result loaded over a beat that was not taken.");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.advance || cmd.fetch) |-> !cmd.accept)
		else $error("New beat accepted during a compare.");
`endif

endmodule

### hw/rtl/exact_pattern_stream_matcher.sv
// Top level of the exact pattern stream matcher.
// Joins the controller and the datapath; depends on epsm_pkg, epsm_ctrl, epsm_datapath.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | func, symbol
//   out     | out_valid / out_stall| match_start, pattern_overflow
//
// Pattern beats, unused codes and text beats that cannot complete a match are taken in idle.
// A text beat that can complete a match compares the pattern byte by byte, FETCH then CHECK,
// through the single read port of each memory, back to idle at the first mismatch; on a full
// match EMIT loads the result once the output register is free. Reset clears the lengths,
// counters and flags; the memories are not cleared. A stalled result waits in the output
// register while later pattern beats and non-matching text beats are still taken.
`timescale 1ns / 1ps

module exact_pattern_stream_matcher (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [epsm_pkg::SYM_W-1:0] symbol,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [epsm_pkg::IDX_W-1:0] match_start,
	output logic                       pattern_overflow
);
	import epsm_pkg::*;

	epsm_cmd_t    cmd;
	epsm_status_t status;

	epsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	epsm_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.func             (func),
		.symbol           (symbol),
		.cmd              (cmd),
		.status           (status),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.match_start      (match_start),
		.pattern_overflow (pattern_overflow)
	);

endmodule

### tb/tb.sv
// Self-checking testbench for exact_pattern_stream_matcher: directed table, then random episodes.
// A behavioral matcher predicts each untyped beat; depends on epsm_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb;
	import epsm_pkg::*;

	localparam int RAND_BEATS  = 1450;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [IDX_W-1:0] start;
		logic             ovf;
	} match_t;

	typedef struct {
		epsm_func_t       op;
		logic [SYM_W-1:0] sym;
		int               reps;
		bit               typed;
		bit               hit;
		logic [IDX_W-1:0] start;
		logic             ovf;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       func = FUNC_NONE;
	logic [SYM_W-1:0] symbol = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [IDX_W-1:0] match_start;
	logic             pattern_overflow;

	logic [SYM_W-1:0] pat_bytes [MAX_PAT];
	int               pat_len = 0;
	logic [SYM_W-1:0] txt_hist [MAX_PAT];
	int               hist_fill = 0;
	logic [IDX_W-1:0] txt_count = '0;
	logic             ovf_flag = 1'b0;

	match_t           due_matches [$];
	int               errors = 0;
	int               beats = 0;
	int               matches_seen = 0;
	int               ovf_matches = 0;
	int               longest_pat = 0;
	int unsigned      cycles = 0;
	int               idle_odds = 0;
	bit               calm = 1'b0;
	logic             hold_go = 1'b0;
	logic             held = 1'b0;
	int               stall_left = 0;

	row_t steps [26] = '{
		'{FUNC_TEXT,   8'h61, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_NONE,   8'h5A, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_APPEND, 8'h61, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h61, 1,  1, 1, 32'd1, 1'b0},
		'{FUNC_TEXT,   8'h61, 1,  1, 1, 32'd2, 1'b0},
		'{FUNC_START,  8'h24, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_APPEND, 8'h24, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h24, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h24, 1,  1, 1, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h24, 1,  1, 1, 32'd1, 1'b0},
		'{FUNC_TEXT,   8'hFF, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h24, 1,  0, 0, 32'd0, 1'b0},
		'{FUNC_START,  8'h00, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h00, 1,  1, 1, 32'd0, 1'b0},
		'{FUNC_APPEND, 8'hFF, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'hFF, 1,  0, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h00, 1,  0, 0, 32'd0, 1'b0},
		'{FUNC_START,  8'h41, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_APPEND, 8'h41, 63, 1, 0, 32'd0, 1'b0},
		'{FUNC_APPEND, 8'h42, 3,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h41, 63, 1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'h41, 1,  1, 1, 32'd0, 1'b1},
		'{FUNC_TEXT,   8'h41, 1,  1, 1, 32'd1, 1'b1},
		'{FUNC_TEXT,   8'h42, 1,  0, 0, 32'd0, 1'b0},
		'{FUNC_START,  8'hFF, 1,  1, 0, 32'd0, 1'b0},
		'{FUNC_TEXT,   8'hFF, 1,  1, 1, 32'd0, 1'b0}
	};

	exact_pattern_stream_matcher uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.symbol           (symbol),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.match_start      (match_start),
		.pattern_overflow (pattern_overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d matches outstanding", $time, due_matches.size());
		$display("TEST FAILED");
		$finish;
	end

	// Advances the matcher by one accepted beat and reports whether it completes an occurrence.
	function automatic bit scan_beat(input logic [1:0] f, input logic [SYM_W-1:0] s,
			output match_t m);
		int k;
		logic [IDX_W-1:0] idx;
		m = '0;
		case (f)
			FUNC_START: begin
				pat_bytes[0] = s;
				pat_len = 1;
				ovf_flag = 1'b0;
				for (k = 0; k < MAX_PAT; k++)
					txt_hist[k] = '0;
				txt_count = '0;
				hist_fill = 0;
				return 1'b0;
			end
			FUNC_APPEND: begin
				if (pat_len < MAX_PAT) begin
					pat_bytes[pat_len] = s;
					pat_len++;
				end else begin
					ovf_flag = 1'b1;
				end
				return 1'b0;
			end
			FUNC_TEXT: begin
				for (k = 0; k < MAX_PAT - 1; k++)
					txt_hist[k] = txt_hist[k + 1];
				txt_hist[MAX_PAT - 1] = s;
				if (hist_fill < MAX_PAT)
					hist_fill++;
				idx = txt_count;
				txt_count = txt_count + 1'b1;
				if (pat_len == 0 || hist_fill < pat_len)
					return 1'b0;
				for (k = 0; k < pat_len; k++)
					if (pat_bytes[k] != txt_hist[MAX_PAT - pat_len + k])
						return 1'b0;
				m.start = idx - IDX_W'(pat_len - 1);
				m.ovf = ovf_flag;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic offer(input logic [1:0] f, input logic [SYM_W-1:0] s, input bit typed,
			input bit t_hit, input match_t t_m);
		match_t m;
		bit hit;
		in_valid <= 1'b1;
		func <= f;
		symbol <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		hit = scan_beat(f, s, m);
		if (typed) begin
			hit = t_hit;
			m = t_m;
		end
		if (hit)
			due_matches.push_back(m);
		if (f != FUNC_NONE)
			beats++;
		if (pat_len > longest_pat)
			longest_pat = pat_len;
	endtask

	task automatic maybe_gap();
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_matches.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_match();
		match_t want;
		if (due_matches.size() == 0) begin
			$display("%0t: match_start expected none actual %h", $time, match_start);
			errors++;
		end else begin
			want = due_matches.pop_front();
			matches_seen++;
			if (want.ovf)
				ovf_matches++;
			if (match_start !== want.start) begin
				$display("%0t: match_start expected %h actual %h", $time, want.start,
					match_start);
				errors++;
			end
			if (pattern_overflow !== want.ovf) begin
				$display("%0t: pattern_overflow expected %b actual %b", $time, want.ovf,
					pattern_overflow);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_match();
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (hold_go && !held) begin
				held <= 1'b1;
				stall_left <= HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				stall_left <= $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic run_table();
		int i, r;
		match_t tm;
		idle_odds = 6;
		for (i = 0; i < 26; i++) begin
			tm.start = steps[i].start;
			tm.ovf = steps[i].ovf;
			for (r = 0; r < steps[i].reps; r++) begin
				maybe_gap();
				offer(steps[i].op, steps[i].sym, steps[i].typed, steps[i].hit, tm);
			end
		end
	endtask

	task automatic run_random();
		int len, ntext, asz, k, pick, first_beat;
		logic [SYM_W-1:0] alpha [3];
		bit first, paused;
		first = 1'b1;
		paused = 1'b0;
		first_beat = beats;
		hold_go <= 1'b1;
		while (beats - first_beat < RAND_BEATS) begin
			pick = $urandom_range(0, 99);
			if (first)
				len = 1;
			else if (pick < 80)
				len = $urandom_range(1, 6);
			else if (pick < 92)
				len = $urandom_range(7, 20);
			else
				len = $urandom_range(60, 70);
			asz = (first || len > 20) ? 1 : $urandom_range(2, 3);
			for (k = 0; k < 3; k++)
				alpha[k] = SYM_W'($urandom_range(0, 255));
			pick = $urandom_range(0, 2);
			idle_odds = first ? 0 : (pick == 0 ? 0 : (pick == 1 ? 12 : 4));
			maybe_gap();
			offer(FUNC_START, alpha[$urandom_range(0, asz - 1)], 0, 0, '0);
			for (k = 1; k < len; k++) begin
				maybe_gap();
				offer(FUNC_APPEND, alpha[$urandom_range(0, asz - 1)], 0, 0, '0);
			end
			ntext = (len > 20) ? $urandom_range(len, len + 40) : $urandom_range(10, 60);
			for (k = 0; k < ntext; k++) begin
				calm = (beats - first_beat > RAND_BEATS - 150);
				maybe_gap();
				pick = $urandom_range(0, 99);
				if (pick < 2)
					offer(FUNC_APPEND, alpha[$urandom_range(0, asz - 1)], 0, 0, '0);
				else if (pick < 4)
					offer(FUNC_NONE, SYM_W'($urandom_range(0, 255)), 0, 0, '0);
				else if (pick < 8)
					offer(FUNC_TEXT, SYM_W'($urandom_range(0, 255)), 0, 0, '0);
				else
					offer(FUNC_TEXT, alpha[$urandom_range(0, asz - 1)], 0, 0, '0);
				if (!paused && beats - first_beat >= RAND_BEATS / 2) begin
					paused = 1'b1;
					drain();
				end
			end
			first = 1'b0;
		end
	endtask

	initial begin
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_table();
		run_random();
		in_valid <= 1'b0;
		while (due_matches.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("Sent %0d pattern and text beats; %0d matches checked, %0d with overflow set.",
			beats, matches_seen, ovf_matches);
		$display("Longest pattern held was %0d bytes, run took %0d cycles.", longest_pat, cycles);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
hw/rtl/epsm_pkg.sv
hw/rtl/epsm_ctrl.sv
hw/rtl/epsm_datapath.sv
hw/rtl/exact_pattern_stream_matcher.sv
tb/tb.sv
